FILE: hw/rtl/i2da_pkg.sv
// shared types and constants for the integer to decimal ascii converter
package i2da_pkg;

	localparam int MAX_WIDTH  = 32;
	localparam int VALUE_W    = 64;
	localparam int NUM_DIGITS = 20;
	localparam int DIGIT_W    = 4;
	localparam int CNT_W      = $clog2(VALUE_W);
	localparam int ND_W       = $clog2(NUM_DIGITS + 1);
	localparam int LEN_W      = ($clog2(MAX_WIDTH + 1) > 6) ? $clog2(MAX_WIDTH + 1) : 6;

	localparam logic [7:0] CHAR_ZERO  = 8'h30;
	localparam logic [7:0] CHAR_MINUS = 8'h2d;

	typedef enum logic [1:0] {
		CELL_HOLD,
		CELL_CLEAR,
		CELL_DABBLE,
		CELL_SHIFT
	} cell_op_t;

	typedef struct packed {
		logic [63:0] value_bits;
		logic        mode;
		logic [5:0]  min_width;
	} item_t;

	typedef struct packed {
		logic [7:0] char_code;
		logic [5:0] text_length;
		logic       last_char;
	} text_t;

endpackage

FILE: hw/rtl/i2da_cell.sv
// one bcd digit cell of the conversion chain
module i2da_cell (
	input  logic                             clk,
	input  i2da_pkg::cell_op_t               op,
	input  logic                             bit_in,
	input  logic [i2da_pkg::DIGIT_W-1:0]     digit_in,
	output logic                             bit_out,
	output logic [i2da_pkg::DIGIT_W-1:0]     digit
);
	import i2da_pkg::*;

	logic [DIGIT_W-1:0] digit_q;
	logic [DIGIT_W-1:0] adj;

	// add three before the shift when the digit would overflow past nine
	always_comb begin
		adj = (digit_q >= DIGIT_W'(5)) ? digit_q + DIGIT_W'(3) : digit_q;
	end

	assign bit_out = adj[DIGIT_W-1];
	assign digit   = digit_q;

	always_ff @(posedge clk) begin
		case (op)
			CELL_CLEAR:  digit_q <= '0;
			CELL_DABBLE: digit_q <= {adj[DIGIT_W-2:0], bit_in};
			CELL_SHIFT:  digit_q <= digit_in;
			default:     digit_q <= digit_q;
		endcase
	end

endmodule

FILE: hw/rtl/integer_to_decimal_ascii.sv
// Converts a 64-bit value to decimal ASCII text, one character per transfer,
// most significant first. A row of twenty BCD digit cells takes the magnitude
// in one bit per cycle, then leading zero digits are shifted out at one per
// cycle until the top digit is non-zero or one digit is left, a setup state
// works out the length, and one character leaves per cycle while the output
// is not stalled. The next item is taken in the cycle after the final
// character enters the output register.
module integer_to_decimal_ascii (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            item_valid,
	output logic            item_stall,
	input  i2da_pkg::item_t item,
	output logic            text_valid,
	input  logic            text_stall,
	output i2da_pkg::text_t text
);
	import i2da_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CONV,
		ST_SKIP,
		ST_SETUP,
		ST_EMIT
	} state_t;

	state_t               state_q;
	logic [VALUE_W-1:0]   bin_q;
	logic [CNT_W-1:0]     cnt_q;
	logic [ND_W-1:0]      nd_q;
	logic                 neg_q;
	logic [LEN_W-1:0]     width_q;
	logic [LEN_W-1:0]     pad_q;
	logic [LEN_W-1:0]     rem_q;
	logic [LEN_W-1:0]     total_q;
	logic                 text_valid_q;
	text_t                text_q;

	cell_op_t             op;
	logic                 accept;
	logic                 emit_load;
	logic                 skip_now;
	logic                 neg_in;
	logic [VALUE_W-1:0]   mag_in;
	logic [LEN_W-1:0]     width_in;
	logic [LEN_W-1:0]     nd_len;
	logic [DIGIT_W-1:0]   top_digit;
	logic [7:0]           next_char;

	logic [NUM_DIGITS-1:0]  carry;
	logic [DIGIT_W-1:0]     digits [NUM_DIGITS];

	for (genvar i = 0; i < NUM_DIGITS; i++) begin : g_cell
		if (i == 0) begin : g_first
			i2da_cell u_cell (
				.clk      (clk),
				.op       (op),
				.bit_in   (bin_q[VALUE_W-1]),
				.digit_in ('0),
				.bit_out  (carry[i]),
				.digit    (digits[i])
			);
		end else begin : g_rest
			i2da_cell u_cell (
				.clk      (clk),
				.op       (op),
				.bit_in   (carry[i-1]),
				.digit_in (digits[i-1]),
				.bit_out  (carry[i]),
				.digit    (digits[i])
			);
		end
	end

	assign top_digit  = digits[NUM_DIGITS-1];
	assign item_stall = (state_q != ST_IDLE);
	assign accept     = item_valid && !item_stall;
	assign emit_load  = (state_q == ST_EMIT) && (!text_valid_q || !text_stall);
	assign skip_now   = (top_digit == '0) && (nd_q > ND_W'(1));
	assign neg_in     = item.mode && item.value_bits[VALUE_W-1];
	assign mag_in     = neg_in ? (~item.value_bits + VALUE_W'(1)) : item.value_bits;
	assign width_in   = (32'(item.min_width) > MAX_WIDTH) ? LEN_W'(MAX_WIDTH)
	                                                      : LEN_W'(item.min_width);
	assign nd_len     = LEN_W'(nd_q);

	always_comb begin
		if (neg_q) begin
			next_char = CHAR_MINUS;
		end else if (pad_q != '0) begin
			next_char = CHAR_ZERO;
		end else begin
			next_char = CHAR_ZERO + {4'b0, top_digit};
		end
	end

	always_comb begin
		case (state_q)
			ST_IDLE: op = accept ? CELL_CLEAR : CELL_HOLD;
			ST_CONV: op = CELL_DABBLE;
			ST_SKIP: op = skip_now ? CELL_SHIFT : CELL_HOLD;
			ST_EMIT: op = (emit_load && !neg_q && pad_q == '0) ? CELL_SHIFT : CELL_HOLD;
			default: op = CELL_HOLD;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			bin_q        <= '0;
			cnt_q        <= '0;
			nd_q         <= '0;
			neg_q        <= 1'b0;
			width_q      <= '0;
			pad_q        <= '0;
			rem_q        <= '0;
			total_q      <= '0;
			text_valid_q <= 1'b0;
			text_q       <= '0;
		end else begin
			if (emit_load) begin
				text_valid_q <= 1'b1;
			end else if (!text_stall) begin
				text_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						bin_q   <= mag_in;
						neg_q   <= neg_in;
						width_q <= width_in;
						cnt_q   <= '0;
						nd_q    <= ND_W'(NUM_DIGITS);
						state_q <= ST_CONV;
					end
				end
				ST_CONV: begin
					bin_q <= bin_q << 1;
					cnt_q <= cnt_q + CNT_W'(1);
					if (cnt_q == CNT_W'(VALUE_W - 1)) begin
						state_q <= ST_SKIP;
					end
				end
				ST_SKIP: begin
					if (skip_now) begin
						nd_q <= nd_q - ND_W'(1);
					end else begin
						state_q <= ST_SETUP;
					end
				end
				ST_SETUP: begin
					if (neg_q) begin
						total_q <= nd_len + LEN_W'(1);
						rem_q   <= nd_len + LEN_W'(1);
						pad_q   <= '0;
					end else if (width_q > nd_len) begin
						total_q <= width_q;
						rem_q   <= width_q;
						pad_q   <= width_q - nd_len;
					end else begin
						total_q <= nd_len;
						rem_q   <= nd_len;
						pad_q   <= '0;
					end
					state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (emit_load) begin
						text_q.char_code      <= next_char;
						text_q.text_length    <= total_q[5:0];
						text_q.last_char      <= (rem_q == LEN_W'(1));
						rem_q                 <= rem_q - LEN_W'(1);
						if (neg_q) begin
							neg_q <= 1'b0;
						end else if (pad_q != '0) begin
							pad_q <= pad_q - LEN_W'(1);
						end
						if (rem_q == LEN_W'(1)) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign text_valid = text_valid_q;
	assign text       = text_q;

endmodule

FILE: hw/rtl/i2da_checker.sv
// port-level checks for the integer to decimal ascii converter
module i2da_checker (
	input logic            clk,
	input logic            arst_n,
	input logic            item_valid,
	input logic            item_stall,
	input i2da_pkg::item_t item,
	input logic            text_valid,
	input logic            text_stall,
	input i2da_pkg::text_t text
);
	import i2da_pkg::*;

	// a stalled transfer keeps its character
	a_text_hold: assert property (@(posedge clk) disable iff (!arst_n)
		text_valid && text_stall |=> text_valid && $stable(text))
		else $error("stalled text transfer changed");

	// an accepted item makes the block busy
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && !item_stall |=> item_stall)
		else $error("block not busy after item transfer");

	// while a non-final character is shown the number is still in progress
	a_busy_mid_text: assert property (@(posedge clk) disable iff (!arst_n)
		text_valid && !text.last_char |-> item_stall)
		else $error("new item taken before its text was complete");

	// only digits or a minus sign appear
	a_char_set: assert property (@(posedge clk) disable iff (!arst_n)
		text_valid |-> text.char_code == CHAR_MINUS
		|| (text.char_code >= CHAR_ZERO && text.char_code <= CHAR_ZERO + 8'd9))
		else $error("character outside digit set");

endmodule

bind integer_to_decimal_ascii i2da_checker u_i2da_checker (.*);
